[rtl/qft_pkg.sv]
// ----------------------------------------------------------------------------
// qft_pkg: shared types and constants of the quoted field tokenizer
// Register indexes, status codes, channel payloads and the queue entry that
// runs from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package qft_pkg;

  // default longest sentence in bytes
  localparam int unsigned MaxSentenceDef = 4096;

  // front-to-back queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEPARATOR   = 3'd0,
    CFG_QUOTE_MARK  = 3'd1,
    CFG_TRIM_ENABLE = 3'd2,
    CFG_TRIM_CHAR   = 3'd3,
    CFG_SKIP_EMPTY  = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [7:0] SeparatorRst  = 8'd32;
  localparam logic [7:0] QuoteMarkRst  = 8'd39;
  localparam logic       TrimEnableRst = 1'b1;
  localparam logic [7:0] TrimCharRst   = 8'd32;
  localparam logic       SkipEmptyRst  = 1'b0;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_QUOTE_NO_SEP = 3'd1,
    ST_UNBALANCED   = 3'd2,
    ST_SEP_IS_QUOTE = 3'd3,
    ST_TOO_LONG     = 3'd4
  } qft_status_e;

  typedef struct packed {
    logic [7:0] separator;
    logic [7:0] quote_mark;
    logic       trim_enable;
    logic [7:0] trim_char;
    logic       skip_empty;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       char_present;
    logic       end_of_sentence;
  } in_t;

  typedef struct packed {
    logic [11:0] token_start;
    logic [12:0] token_length;
    logic [12:0] token_index;
    logic [2:0]  status;
    logic        token_last;
  } out_t;

  // classified byte as it waits in the queue
  typedef struct packed {
    logic present;
    logic eos;
    logic is_sep;
    logic is_quote;
    logic is_trim;
    logic sep_is_quote;
  } item_t;

endpackage

`default_nettype wire

[rtl/qft_stream_if.sv]
// ----------------------------------------------------------------------------
// qft_stream_if: valid/ready channel
// One word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface qft_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[rtl/qft_front.sv]
// ----------------------------------------------------------------------------
// qft_front: byte classifier and item queue
// Compares each byte against the separator, quote and trim bytes, drops
// words that carry neither a byte nor an end, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module qft_front
  import qft_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  input  wire in_t   in_payload_i,
  output logic       in_ready_o,
  output logic       item_valid_o,
  output item_t      item_o,
  input  wire logic  item_ready_i
);

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q, count_d;
  item_t                cls;
  logic                 push, pop;

  // classification
  always_comb begin
    cls.present      = in_payload_i.char_present;
    cls.eos          = in_payload_i.end_of_sentence;
    cls.is_sep       = in_payload_i.char_byte == cfg_i.separator;
    cls.is_quote     = in_payload_i.char_byte == cfg_i.quote_mark;
    cls.is_trim      = in_payload_i.char_byte == cfg_i.trim_char;
    cls.sep_is_quote = cfg_i.separator == cfg_i.quote_mark;
  end

  // queue handshake
  assign in_ready_o   = count_q != (QueuePtrW+1)'(QueueDepth);
  assign push         = in_valid_i && in_ready_o && (cls.present || cls.eos);
  assign item_valid_o = count_q != '0;
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("queue fill level above depth");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid_o)
    else $error("queue full but shows no item");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1)
    else $error("push without pop did not grow the queue");

endmodule

`default_nettype wire

[rtl/qft_back.sv]
// ----------------------------------------------------------------------------
// qft_back: token state and result output
// Tracks position, quotes and trim bounds for the sentence, closes tokens,
// flags errors, and sends up to two result words per item.
// ----------------------------------------------------------------------------
`default_nettype none

module qft_back
  import qft_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = MaxSentenceDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  output logic       item_ready_o,
  output logic       out_valid_o,
  output out_t       out_o,
  input  wire logic  out_ready_i
);

  localparam int unsigned PosW = $clog2(MAX_SENTENCE + 1);
  typedef logic [PosW-1:0] pos_t;

  function automatic out_t make_res(pos_t start, pos_t len, pos_t idx, logic [2:0] st);
    logic [31:0] s32, l32, i32;
    out_t        r;
    s32 = 32'(start);
    l32 = 32'(len);
    i32 = 32'(idx);
    r.token_start  = s32[11:0];
    r.token_length = l32[12:0];
    r.token_index  = i32[12:0];
    r.status       = st;
    r.token_last   = 1'b0;
    return r;
  endfunction

  function automatic out_t close_tok(pos_t ws, pos_t wl, logic ks, pos_t fk, pos_t lk,
                                     pos_t idx, logic trim_en);
    pos_t s, n;
    s = ws;
    n = wl;
    if (wl != '0 && trim_en) begin
      if (ks) begin
        s = fk;
        n = lk - fk + 1'b1;
      end else begin
        n = '0;
      end
    end
    return make_res(s, n, idx, ST_OK);
  endfunction

  // sentence state
  pos_t position_q, word_start_q, word_length_q, first_kept_q, last_kept_q, count_q;
  logic outside_q, just_closed_q, kept_seen_q, error_hold_q;

  pos_t position_m, word_start_m, word_length_m, first_kept_m, last_kept_m, count_m;
  logic outside_m, just_closed_m, kept_seen_m;

  qft_status_e err;
  logic        take, c0_v, c1_v;
  out_t        c0, c1, res0, res1;
  logic [1:0]  n_res;

  // output stage
  logic out_valid_q, pend_valid_q;
  out_t out_q, pend_q;
  logic out_free;

  assign out_free     = !out_valid_q || out_ready_i;
  assign item_ready_o = !pend_valid_q && out_free;
  assign take         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  // item processing
  always_comb begin
    position_m    = position_q;
    word_start_m  = word_start_q;
    word_length_m = word_length_q;
    first_kept_m  = first_kept_q;
    last_kept_m   = last_kept_q;
    count_m       = count_q;
    outside_m     = outside_q;
    just_closed_m = just_closed_q;
    kept_seen_m   = kept_seen_q;
    err           = ST_OK;
    c0_v          = 1'b0;
    c1_v          = 1'b0;
    c0            = '0;
    c1            = '0;

    if (!error_hold_q) begin
      if (item_i.sep_is_quote) begin
        err = ST_SEP_IS_QUOTE;
      end else if (item_i.present && just_closed_q && !item_i.is_sep) begin
        err = ST_QUOTE_NO_SEP;
      end else if (item_i.present && position_q >= PosW'(MAX_SENTENCE)) begin
        err = ST_TOO_LONG;
      end

      // byte: extend the token or close it at a separator
      if (err == ST_OK && item_i.present) begin
        just_closed_m = 1'b0;
        if (item_i.is_quote || !(outside_q && item_i.is_sep)) begin
          if (item_i.is_quote) begin
            if (!outside_q) begin
              just_closed_m = 1'b1;
            end
            outside_m = !outside_q;
          end
          word_length_m = word_length_q + 1'b1;
          if (!item_i.is_trim) begin
            if (!kept_seen_q) begin
              first_kept_m = position_q;
              kept_seen_m  = 1'b1;
            end
            last_kept_m = position_q;
          end
        end else begin
          c0_v = (word_length_q != '0) || !cfg_i.skip_empty;
          c0   = close_tok(word_start_q, word_length_q, kept_seen_q, first_kept_q,
                           last_kept_q, count_q, cfg_i.trim_enable);
          count_m       = count_q + PosW'(c0_v);
          word_start_m  = position_q + 1'b1;
          word_length_m = '0;
          kept_seen_m   = 1'b0;
        end
        position_m = position_q + 1'b1;
      end

      // end of sentence: close the final token
      if (err == ST_OK && item_i.eos) begin
        if (!outside_m) begin
          err = ST_UNBALANCED;
        end else begin
          c1_v = (word_length_m != '0) || !cfg_i.skip_empty;
          c1   = close_tok(word_start_m, word_length_m, kept_seen_m, first_kept_m,
                           last_kept_m, count_m, cfg_i.trim_enable);
        end
      end
    end
  end

  // result words, packed to the front
  always_comb begin
    res0  = '0;
    res1  = '0;
    n_res = 2'd0;
    if (err != ST_OK) begin
      res0            = make_res('0, '0, count_m, err);
      res0.token_last = 1'b1;
      n_res           = 2'd1;
    end else if (c0_v && c1_v) begin
      res0            = c0;
      res1            = c1;
      res1.token_last = 1'b1;
      n_res           = 2'd2;
    end else if (c0_v) begin
      res0            = c0;
      res0.token_last = item_i.eos;
      n_res           = 2'd1;
    end else if (c1_v) begin
      res0            = c1;
      res0.token_last = 1'b1;
      n_res           = 2'd1;
    end
  end

  // sentence state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      word_start_q  <= '0;
      word_length_q <= '0;
      first_kept_q  <= '0;
      last_kept_q   <= '0;
      count_q       <= '0;
      outside_q     <= 1'b1;
      just_closed_q <= 1'b0;
      kept_seen_q   <= 1'b0;
      error_hold_q  <= 1'b0;
    end else if (take) begin
      if (item_i.eos) begin
        position_q    <= '0;
        word_start_q  <= '0;
        word_length_q <= '0;
        first_kept_q  <= '0;
        last_kept_q   <= '0;
        count_q       <= '0;
        outside_q     <= 1'b1;
        just_closed_q <= 1'b0;
        kept_seen_q   <= 1'b0;
        error_hold_q  <= 1'b0;
      end else if (!error_hold_q) begin
        if (err != ST_OK) begin
          error_hold_q <= 1'b1;
        end else begin
          position_q    <= position_m;
          word_start_q  <= word_start_m;
          word_length_q <= word_length_m;
          first_kept_q  <= first_kept_m;
          last_kept_q   <= last_kept_m;
          count_q       <= count_m;
          outside_q     <= outside_m;
          just_closed_q <= just_closed_m;
          kept_seen_q   <= kept_seen_m;
        end
      end
    end
  end

  // output and second-word valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (pend_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end
    end else if (take && n_res != 2'd0) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= n_res == 2'd2;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pend_valid_q) begin
      if (out_free) begin
        out_q <= pend_q;
      end
    end else if (take && n_res != 2'd0) begin
      out_q  <= res0;
      pend_q <= res1;
    end
  end

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("second word held with no word in the output register");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.token_last)
    else $error("error word not marked last");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.eos |=> position_q == '0 && outside_q && !error_hold_q)
    else $error("sentence state not cleared at end");

  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_hold_q && !(take && item_i.eos) |=> $stable(position_q) && error_hold_q)
    else $error("state moved while discarding after an error");

endmodule

`default_nettype wire

[rtl/quoted_field_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_top: quote-aware delimited field splitter
// Splits a byte stream into tokens at separators outside quotes and reports
// offset, length and number of each token, with optional trimming.
// ----------------------------------------------------------------------------
//  port     | dir | word
//  ---------+-----+-------------------------------------------------------
//  in_i     | in  | char_byte, char_present, end_of_sentence
//  out_o    | out | token_start, token_length, token_index, status, token_last
//  cfg_*    | in  | write enable, register index, 8-bit data
//
//  One byte per cycle is taken while the four-entry queue has room. Each
//  byte is queued, and its result is then registered in the output register.
//  A byte that closes a token and also ends the sentence gives two words; the
//  second waits in a holding register and stalls the back end; the queue absorbs this.
//  Reset restores register defaults and empties queue and output stage.
//  Either side may stall at any time; the queue lets input continue while a
//  result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_field_tokenizer_top
  import qft_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = MaxSentenceDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  qft_stream_if.sink               in_i,
  qft_stream_if.source             out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  item_valid, item_ready;
  item_t item;
  out_t  res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.separator   <= SeparatorRst;
      cfg_q.quote_mark  <= QuoteMarkRst;
      cfg_q.trim_enable <= TrimEnableRst;
      cfg_q.trim_char   <= TrimCharRst;
      cfg_q.skip_empty  <= SkipEmptyRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEPARATOR:   cfg_q.separator   <= cfg_data_i;
        CFG_QUOTE_MARK:  cfg_q.quote_mark  <= cfg_data_i;
        CFG_TRIM_ENABLE: cfg_q.trim_enable <= cfg_data_i[0];
        CFG_TRIM_CHAR:   cfg_q.trim_char   <= cfg_data_i;
        CFG_SKIP_EMPTY:  cfg_q.skip_empty  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  qft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_payload_i (in_i.payload),
    .in_ready_o   (in_i.ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  qft_back #(
    .MAX_SENTENCE (MAX_SENTENCE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .out_valid_o  (out_o.valid),
    .out_o        (res),
    .out_ready_i  (out_o.ready)
  );

  assign out_o.payload = res;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quoted_field_tokenizer_top
// Feeds sentences byte by byte through the input channel and predicts
// every token word (offset, length, number, status, last flag) with an
// in-bench tokenizer. Covers directed corner cases, two maximum-length
// sentences and random sentences under several register settings, with
// random bursts on the input side and stall patterns on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import qft_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  qft_stream_if #(.payload_t(in_t))  byte_ch ();
  qft_stream_if #(.payload_t(out_t)) token_ch ();

  quoted_field_tokenizer_top #(
    .MAX_SENTENCE(MaxSentenceDef)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (byte_ch),
    .out_o     (token_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // stimulus and expectation stores
  in_t  bytes_pending[$];
  out_t tokens_due[$];
  out_t fresh[$];
  int   words_queued;
  int   words_taken;
  int   random_words;
  int   tokens_checked;
  int   error_tokens;
  int   mismatches;
  int   phases;
  bit   calm;

  // driver burst state
  int burst_left;
  int gap_left;

  // receiver stall pattern
  logic [15:0] stall_mask;
  int          stall_tick;

  // tokenizer shadow: registers and per-sentence state
  cfg_t shadow;
  int   pos;
  int   word_start;
  int   word_len;
  int   first_kept;
  int   last_kept;
  int   token_count;
  bit   outside;
  bit   just_closed;
  bit   kept_seen;
  bit   error_hold;

  function automatic void clear_sentence();
    pos = 0;
    word_start = 0;
    word_len = 0;
    first_kept = 0;
    last_kept = 0;
    token_count = 0;
    outside = 1'b1;
    just_closed = 1'b0;
    kept_seen = 1'b0;
    error_hold = 1'b0;
  endfunction

  function automatic out_t make_token(int s, int n, int idx, qft_status_e st);
    out_t t;
    t.token_start = s[11:0];
    t.token_length = n[12:0];
    t.token_index = idx[12:0];
    t.status = st;
    t.token_last = 1'b0;
    return t;
  endfunction

  // close the token in progress, honoring trim and skip settings
  function automatic void close_token();
    int s;
    int n;
    if (word_len > 0) begin
      s = word_start;
      n = word_len;
      if (shadow.trim_enable) begin
        if (kept_seen) begin
          s = first_kept;
          n = last_kept - first_kept + 1;
        end else begin
          n = 0;
        end
      end
      fresh = {fresh, make_token(s, n, token_count, ST_OK)};
      token_count++;
    end else if (!shadow.skip_empty) begin
      fresh = {fresh, make_token(word_start, 0, token_count, ST_OK)};
      token_count++;
    end
  endfunction

  // predict the token words caused by one accepted input word
  function automatic void split_byte(in_t w);
    qft_status_e err;
    logic [7:0]  b;
    out_t        bad;
    err = ST_OK;
    b = w.char_byte;
    fresh.delete();
    if (!w.char_present && !w.end_of_sentence) return;
    if (error_hold) begin
      if (w.end_of_sentence) clear_sentence();
      return;
    end
    if (shadow.separator == shadow.quote_mark) err = ST_SEP_IS_QUOTE;
    else if (w.char_present && just_closed && b != shadow.separator) err = ST_QUOTE_NO_SEP;
    else if (w.char_present && pos >= MaxSentenceDef) err = ST_TOO_LONG;

    if (err == ST_OK && w.char_present) begin
      just_closed = 1'b0;
      if (b == shadow.quote_mark || !(outside && b == shadow.separator)) begin
        if (b == shadow.quote_mark) begin
          if (!outside) just_closed = 1'b1;
          outside = !outside;
        end
        word_len++;
        if (b != shadow.trim_char) begin
          if (!kept_seen) begin
            first_kept = pos;
            kept_seen = 1'b1;
          end
          last_kept = pos;
        end
      end else begin
        close_token();
        word_start = pos + 1;
        word_len = 0;
        kept_seen = 1'b0;
      end
      pos++;
    end

    if (err == ST_OK && w.end_of_sentence) begin
      if (!outside) err = ST_UNBALANCED;
      else close_token();
    end

    // an error replaces anything else and holds off the rest of the sentence
    if (err != ST_OK) begin
      bad = make_token(0, 0, token_count, err);
      bad.token_last = 1'b1;
      tokens_due = {tokens_due, bad};
      if (w.end_of_sentence) clear_sentence();
      else error_hold = 1'b1;
      return;
    end

    if (w.end_of_sentence && fresh.size() > 0) fresh[fresh.size()-1].token_last = 1'b1;
    tokens_due = {tokens_due, fresh};
    if (w.end_of_sentence) clear_sentence();
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        split_byte(byte_ch.payload);
        words_taken++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_ch.valid <= 1'b0;
        end else if (bytes_pending.size() > 0) begin
          byte_ch.payload <= bytes_pending.pop_front();
          byte_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if (!calm && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 8);
          end
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output stall pattern, reshuffled now and then at random
  always @(posedge clk) begin
    if (rst_n) begin
      stall_tick++;
      if (stall_tick % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = 16'hFFFF;
          1: stall_mask = 16'($urandom() & $urandom());
          default: stall_mask = 16'($urandom());
        endcase
        if (stall_mask == 16'h0) stall_mask = 16'h0001;
      end
      token_ch.ready <= calm ? 1'b1 : stall_mask[stall_tick % 16];
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && token_ch.valid && token_ch.ready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected token word: start %0d length %0d index %0d status %0d",
               token_ch.payload.token_start, token_ch.payload.token_length,
               token_ch.payload.token_index, token_ch.payload.status);
        mismatches++;
      end else begin
        check_field("token_start", tokens_due[0].token_start, token_ch.payload.token_start);
        check_field("token_length", tokens_due[0].token_length,
                    token_ch.payload.token_length);
        check_field("token_index", tokens_due[0].token_index, token_ch.payload.token_index);
        check_field("status", tokens_due[0].status, token_ch.payload.status);
        check_field("token_last", tokens_due[0].token_last, token_ch.payload.token_last);
        if (tokens_due[0].status != ST_OK) error_tokens++;
        void'(tokens_due.pop_front());
        tokens_checked++;
      end
    end
  end

  // hard limit on run time
  initial begin
    #20ms;
    $display("FAIL quoted_field_tokenizer_top");
    $finish;
  end

  task automatic push_word(logic [7:0] c, logic present, logic eos);
    in_t w;
    w.char_byte = c;
    w.char_present = present;
    w.end_of_sentence = eos;
    bytes_pending = {bytes_pending, w};
    words_queued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
  endtask

  // program all registers; only called while the block is idle
  task automatic set_fields(logic [7:0] sep, logic [7:0] q, logic te, logic [7:0] tc,
                            logic se);
    write_reg(CFG_SEPARATOR, sep);
    write_reg(CFG_QUOTE_MARK, q);
    write_reg(CFG_TRIM_ENABLE, {7'd0, te});
    write_reg(CFG_TRIM_CHAR, tc);
    write_reg(CFG_SKIP_EMPTY, {7'd0, se});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    shadow.separator = sep;
    shadow.quote_mark = q;
    shadow.trim_enable = te;
    shadow.trim_char = tc;
    shadow.skip_empty = se;
    phases++;
  endtask

  // wait until all words are taken and all tokens have arrived
  task automatic drain();
    int waited;
    waited = 0;
    do @(negedge clk); while (words_taken != words_queued);
    while (tokens_due.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    if (tokens_due.size() != 0) begin
      $error("%0d token words never arrived", tokens_due.size());
      mismatches++;
      tokens_due.delete();
    end
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom()); while (c == shadow.separator || c == shadow.quote_mark);
    return c;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h20;
      3: return 8'h2C;
      4: return 8'h22;
      default: return 8'($urandom());
    endcase
  endfunction

  // one random sentence: mostly well formed, optionally with noise
  task automatic queue_sentence(bit noisy);
    logic [7:0] s[$];
    logic [7:0] c;
    int         ntok;
    int         k;
    ntok = $urandom_range(1, 6);
    for (k = 0; k < ntok; k++) begin
      if (k > 0) s = {s, shadow.separator};
      repeat ($urandom_range(0, 2)) s = {s, shadow.trim_char};
      repeat ($urandom_range(0, 5)) s = {s, plain_byte()};
      if ($urandom_range(0, 2) == 0) begin
        s = {s, shadow.quote_mark};
        repeat ($urandom_range(0, 4)) begin
          do c = 8'($urandom()); while (c == shadow.quote_mark);
          if ($urandom_range(0, 3) == 0) c = shadow.separator;
          s = {s, c};
        end
        s = {s, shadow.quote_mark};
      end else begin
        repeat ($urandom_range(0, 2)) s = {s, shadow.trim_char};
      end
    end
    if (noisy && s.size() > 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, s.size() - 1);
        s[k] = $urandom_range(0, 1) ? shadow.quote_mark : pick_byte();
      end
    end
    foreach (s[i]) begin
      if ($urandom_range(0, 15) == 0) push_word(8'($urandom()), 1'b0, 1'b0);
      push_word(s[i], 1'b1, (i == s.size() - 1) && $urandom_range(0, 1));
      random_words++;
    end
    // end marker on the last byte or as an end-only word
    if (s.size() == 0 || !bytes_pending[bytes_pending.size()-1].end_of_sentence) begin
      push_word(8'($urandom()), 1'b0, 1'b1);
      random_words++;
    end
  endtask

  // maximum length sentence; overflow adds one byte past the limit and a separator
  task automatic queue_long_sentence(bit overflow);
    int i;
    for (i = 0; i < MaxSentenceDef - 1; i++)
      push_word((i % 29 == 28) ? shadow.separator : plain_byte(), 1'b1, 1'b0);
    push_word(shadow.separator, 1'b1, 1'b0);
    if (overflow) begin
      push_word(8'h7A, 1'b1, 1'b0);
      push_word(shadow.separator, 1'b1, 1'b0);
    end
    push_word(8'($urandom()), 1'b0, 1'b1);
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SEPARATOR;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.payload = '0;
    token_ch.ready = 1'b0;
    stall_mask = 16'hFFFF;
    stall_tick = 0;
    burst_left = 0;
    gap_left = 0;
    calm = 1'b0;
    words_queued = 0;
    words_taken = 0;
    random_words = 0;
    tokens_checked = 0;
    error_tokens = 0;
    mismatches = 0;
    phases = 0;
    shadow.separator = SeparatorRst;
    shadow.quote_mark = QuoteMarkRst;
    shadow.trim_enable = TrimEnableRst;
    shadow.trim_char = TrimCharRst;
    shadow.skip_empty = SkipEmptyRst;
    clear_sentence();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: quoted separator, closing quote as last byte
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'h20, 1'b1, 1'b0);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h20, 1'b1, 1'b0);
    push_word(8'h27, 1'b1, 1'b0);
    push_word(8'h20, 1'b1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'h27, 1'b1, 1'b1);
    // empty sentence, then an item carrying nothing
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hFF, 1'b0, 1'b0);
    // closing quote followed by a non-separator; rest ignored
    push_word(8'h27, 1'b1, 1'b0);
    push_word(8'h78, 1'b1, 1'b0);
    push_word(8'h27, 1'b1, 1'b0);
    push_word(8'h79, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    // unbalanced quote
    push_word(8'h27, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    drain();

    // trimmed-away token kept under skip, empty token dropped, last token dropped
    set_fields(8'h2C, 8'h22, 1'b1, 8'h20, 1'b1);
    push_word(8'h20, 1'b1, 1'b0);
    push_word(8'h2C, 1'b1, 1'b0);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h20, 1'b1, 1'b0);
    push_word(8'h2C, 1'b1, 1'b0);
    push_word(8'h2C, 1'b1, 1'b0);
    push_word(8'h22, 1'b1, 1'b0);
    push_word(8'h2C, 1'b1, 1'b0);
    push_word(8'h22, 1'b1, 1'b1);
    push_word(8'h63, 1'b1, 1'b0);
    push_word(8'h2C, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    drain();

    // separator equal to quote mark, on a byte and on an end-only word
    set_fields(8'h00, 8'h00, 1'b0, 8'hFF, 1'b0);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    drain();

    // full-length sentences: start wrap past the last offset, then too long
    set_fields(8'h20, 8'h27, 1'b1, 8'h20, 1'b0);
    queue_long_sentence(1'b0);
    queue_long_sentence(1'b1);
    drain();

    // random sentences under changing settings, two of them extremes
    while (random_words < 2000) begin
      calm = (phases % 4 == 3);
      if (phases == 4) set_fields(8'hFF, 8'h00, 1'b0, 8'hFF, 1'b1);
      else if (phases == 5) set_fields(8'h00, 8'hFF, 1'b1, 8'h00, 1'b0);
      else set_fields(pick_byte(), ($urandom_range(0, 15) == 0) ? shadow.separator :
                      pick_byte(), 1'($urandom_range(0, 1)), pick_byte(),
                      1'($urandom_range(0, 1)));
      repeat (50) queue_sentence($urandom_range(0, 4) == 0);
      drain();
    end

    $display("covered %0d input words (%0d random) over %0d register settings",
             words_taken, random_words, phases);
    $display("checked %0d token words, %0d of them error reports", tokens_checked,
             error_tokens);
    if (mismatches == 0) begin
      $display("PASS quoted_field_tokenizer_top");
    end else begin
      $display("FAIL quoted_field_tokenizer_top");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qft_pkg.sv
rtl/qft_stream_if.sv
rtl/qft_front.sv
rtl/qft_back.sv
rtl/quoted_field_tokenizer_top.sv
bench/testbench.sv
